// ----- src/rtfd_pkg.sv -----
package rtfd_pkg;

	typedef logic [7:0] byte_t;

	// Frame delimiters.
	localparam byte_t HDR_0      = 8'hAA;
	localparam byte_t HDR_1      = 8'hFF;
	localparam byte_t HDR_2      = 8'h03;
	localparam byte_t HDR_3      = 8'h00;
	localparam byte_t FOOTER_0   = 8'h55;
	localparam byte_t FOOTER_1   = 8'hCC;
	localparam int    HDR_LEN    = 4;
	localparam int    TGT_BYTES  = 8;
	localparam int    TGT_W      = TGT_BYTES * 8;

	// Expected header byte at a given match count.
	function automatic byte_t hdr_byte(input logic [1:0] idx);
		byte_t b;
		case (idx)
			2'd0:    b = HDR_0;
			2'd1:    b = HDR_1;
			2'd2:    b = HDR_2;
			default: b = HDR_3;
		endcase
		return b;
	endfunction

	// Sign-magnitude to two's complement. Bit 15 set means positive.
	function automatic logic signed [15:0] sm_decode(input logic [15:0] raw);
		logic [15:0] mag;
		mag = {1'b0, raw[14:0]};
		if (raw[15]) begin
			return signed'(mag);
		end
		return signed'(16'd0 - mag);
	endfunction

endpackage

// ----- src/rtfd_byte_if.sv -----
interface rtfd_byte_if import rtfd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/rtfd_target_if.sv -----
interface rtfd_target_if ();
	logic               valid;
	logic               ready;
	logic [1:0]         target_slot;
	logic               target_valid;
	logic signed [15:0] x_mm;
	logic signed [15:0] y_mm;
	logic signed [15:0] velocity;
	logic [15:0]        dist_res;
	logic               last_target;

	modport source (
		output valid, output target_slot, output target_valid, output x_mm,
		output y_mm, output velocity, output dist_res, output last_target,
		input ready
	);
	modport sink (
		input valid, input target_slot, input target_valid, input x_mm,
		input y_mm, input velocity, input dist_res, input last_target,
		output ready
	);
endinterface

// ----- src/rtfd_parser.sv -----
module rtfd_parser import rtfd_pkg::*; #(
	parameter int TARGET_COUNT = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rtfd_byte_if.sink                     rx,
	input  logic                          can_load,
	output logic                          load,
	output logic [TARGET_COUNT*TGT_W-1:0] frame
);
	localparam int DATA_BYTES = TARGET_COUNT * TGT_BYTES;
	localparam int FOOTER_POS = HDR_LEN + DATA_BYTES;
	localparam int POS_W      = $clog2(FOOTER_POS + 2);
	localparam int FRAME_W    = TARGET_COUNT * TGT_W;

	logic [POS_W-1:0]   pos_q;
	logic               footer_ok_q;
	logic [FRAME_W-1:0] frame_q;
	logic               take;
	logic               at_last;

	assign at_last  = (pos_q == POS_W'(FOOTER_POS + 1));
	// Only the closing footer byte needs the result buffer to be free.
	assign rx.ready = !at_last || can_load;
	assign take     = rx.valid && rx.ready;
	assign load     = take && at_last && footer_ok_q && (rx.rx_byte == FOOTER_1);
	assign frame    = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			footer_ok_q <= 1'b0;
		end else if (take) begin
			if (pos_q < POS_W'(HDR_LEN)) begin
				if (rx.rx_byte == hdr_byte(pos_q[1:0])) begin
					pos_q <= pos_q + 1'b1;
				end else if (rx.rx_byte == HDR_0) begin
					pos_q <= POS_W'(1);
				end else begin
					pos_q <= '0;
				end
			end else if (pos_q < POS_W'(FOOTER_POS)) begin
				pos_q <= pos_q + 1'b1;
			end else if (pos_q == POS_W'(FOOTER_POS)) begin
				footer_ok_q <= (rx.rx_byte == FOOTER_0);
				pos_q       <= pos_q + 1'b1;
			end else begin
				footer_ok_q <= 1'b0;
				pos_q       <= '0;
			end
		end
	end

	// Target bytes enter at the top, so the first byte of the frame ends up
	// in the lowest byte lane.
	always_ff @(posedge clk) begin
		if (take && (pos_q >= POS_W'(HDR_LEN)) && (pos_q < POS_W'(FOOTER_POS))) begin
			frame_q <= {rx.rx_byte, frame_q[FRAME_W-1:8]};
		end
	end
endmodule

// ----- src/rtfd_emitter.sv -----
module rtfd_emitter import rtfd_pkg::*; #(
	parameter int TARGET_COUNT = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [TARGET_COUNT*TGT_W-1:0] frame,
	output logic                          can_load,
	rtfd_target_if.source                 targets
);
	localparam int FRAME_W = TARGET_COUNT * TGT_W;
	localparam int CNT_W   = $clog2(TARGET_COUNT + 1);

	logic [FRAME_W-1:0] buf_q;
	logic [CNT_W-1:0]   remain_q;
	logic [1:0]         slot_q;
	logic               out_valid_q;
	logic               adv;
	logic [TGT_W-1:0]   tgt;

	assign tgt      = buf_q[TGT_W-1:0];
	assign adv      = (remain_q != '0) && (!out_valid_q || targets.ready);
	assign can_load = (remain_q == '0) || ((remain_q == CNT_W'(1)) && adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q    <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (targets.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				remain_q <= CNT_W'(TARGET_COUNT);
				slot_q   <= '0;
			end else if (adv) begin
				remain_q <= remain_q - 1'b1;
				slot_q   <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= frame;
		end else if (adv) begin
			buf_q <= buf_q >> TGT_W;
		end
		if (adv) begin
			targets.target_slot  <= slot_q;
			targets.target_valid <= |tgt;
			targets.x_mm         <= sm_decode(tgt[15:0]);
			targets.y_mm         <= sm_decode(tgt[31:16]);
			targets.velocity     <= sm_decode(tgt[47:32]);
			targets.dist_res     <= tgt[63:48];
			targets.last_target  <= (remain_q == CNT_W'(1));
		end
	end

	assign targets.valid = out_valid_q;
endmodule

// ----- src/radar_target_frame_decoder.sv -----
// Channel   Role    Transfer carries
// rx        sink    one received serial byte (rx_byte)
// targets   source  one decoded target (slot, valid flag, x, y, speed,
//                   resolution, last-of-frame flag)
//
// Rx is ready in every cycle except on the closing footer byte while the
// previous frame still has results to drain. A good frame yields
// TARGET_COUNT results from the result register, one per cycle while
// targets is ready. Reset clears the parser position, the footer flag and
// the result queue; stored target bytes are not cleared. A stalled targets
// channel holds the current result and stops the result buffer from
// advancing.
module radar_target_frame_decoder import rtfd_pkg::*; #(
	parameter int TARGET_COUNT = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	rtfd_byte_if.sink     rx,
	rtfd_target_if.source targets
);
	// Frame data moves in one step from the parser's byte shift line into
	// the emitter's result buffer when the closing footer byte checks out.
	logic                          load;
	logic                          can_load;
	logic [TARGET_COUNT*TGT_W-1:0] frame;

	// Header hunt, target byte capture and footer check.
	rtfd_parser #(
		.TARGET_COUNT(TARGET_COUNT)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.can_load (can_load),
		.load     (load),
		.frame    (frame)
	);

	// Per-target decode into the registered result, one target per transfer.
	rtfd_emitter #(
		.TARGET_COUNT(TARGET_COUNT)
	) u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.can_load (can_load),
		.targets  (targets)
	);
endmodule
